/* hw/rtl/ifd_pkg.sv */
// Package for the IMU frame deframer: frame record type and framing constants.
// No dependencies; used by every module of the block.
`default_nettype none

package ifd_pkg;

  // Framing constants
  localparam int unsigned FRAME_BYTES   = 18;
  localparam int unsigned PAYLOAD_BYTES = FRAME_BYTES - 2;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES);
  localparam logic [7:0]  HDR_BYTE      = 8'hA5;

  // Angle scaling: word / 10 toward zero, plus offset
  localparam int unsigned        QUOT_W      = 13;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [15:0]        RECIP_TEN   = 16'd52429;
  localparam logic signed [13:0] ANGLE_OFS   = 14'sd1800;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One received frame as handed from the front to the back
  typedef struct packed {
    logic        ok;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] rate_z;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } ifd_frame_t;

endpackage

`default_nettype wire

/* hw/rtl/ifd_front.sv */
// Front end of the IMU frame deframer: header hunt, payload collection, checksum.
// Depends on ifd_pkg; pushes finished frames toward ifd_queue.
`default_nettype none

module ifd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rx_valid_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              q_full_i,
  output      logic              rx_stall_o,
  output      logic              push_o,
  output      ifd_pkg::ifd_frame_t frame_o
);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam int unsigned SHIFT_W = 8 * (ifd_pkg::PAYLOAD_BYTES - 1);
  localparam logic [ifd_pkg::CNT_W-1:0] LAST_CNT =
    ifd_pkg::CNT_W'(ifd_pkg::PAYLOAD_BYTES - 1);

  logic [1:0]                phase_q, phase_d;
  logic [ifd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [SHIFT_W-1:0]        shift_q;
  logic                      accept;
  logic                      last_byte;
  logic [15:0]               w7;
  logic [15:0]               csum;

  // Hold bytes while the queue has no room
  assign rx_stall_o = q_full_i;
  assign accept     = rx_valid_i && !rx_stall_o;
  assign last_byte  = (phase_q == PH_DATA) && (cnt_q == LAST_CNT);

  // Phase and byte count
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT2: begin
          phase_d = (rx_byte_i == ifd_pkg::HDR_BYTE) ? PH_DATA : PH_HUNT1;
          cnt_d   = '0;
        end
        PH_DATA: begin
          if (last_byte) begin
            phase_d = PH_HUNT1;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          phase_d = (rx_byte_i == ifd_pkg::HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
          cnt_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Shift payload bytes in; oldest byte ends up at the bottom
  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PH_DATA) && !last_byte) begin
      shift_q <= {rx_byte_i, shift_q[SHIFT_W-1:8]};
    end
  end

  // Checksum word arrives with the final byte
  assign w7   = {rx_byte_i, shift_q[SHIFT_W-1 -: 8]};
  assign csum = shift_q[63:48] + shift_q[79:64] + shift_q[95:80] + shift_q[111:96];

  assign push_o          = accept && last_byte;
  assign frame_o.ok      = (csum == w7);
  assign frame_o.accel_x = shift_q[15:0];
  assign frame_o.accel_y = shift_q[31:16];
  assign frame_o.accel_z = shift_q[47:32];
  assign frame_o.rate_z  = shift_q[63:48];
  assign frame_o.yaw     = shift_q[79:64];
  assign frame_o.pitch   = shift_q[95:80];
  assign frame_o.roll    = shift_q[111:96];

endmodule

`default_nettype wire

/* hw/rtl/ifd_queue.sv */
// Two-slot frame queue between the deframer front and back.
// Depends on ifd_pkg for the frame record type.
`default_nettype none

module ifd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ifd_pkg::ifd_frame_t frame_i,
  input  wire logic                pop_i,
  output      logic                full_o,
  output      logic                valid_o,
  output      ifd_pkg::ifd_frame_t head_o
);

  logic [1:0]          cnt_q, cnt_d;
  ifd_pkg::ifd_frame_t head_q, tail_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = head_q;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Slot data: head is always the oldest entry
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (push_i && (cnt_q == 2'd1)) begin
        head_q <= frame_i;
      end else begin
        head_q <= tail_q;
        if (push_i) begin
          tail_q <= frame_i;
        end
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= frame_i;
      end else begin
        tail_q <= frame_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ifd_back.sv */
// Back end of the IMU frame deframer: angle scaling pipeline and result register.
// Depends on ifd_pkg; drains frames from ifd_queue.
`default_nettype none

module ifd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire ifd_pkg::ifd_frame_t q_head_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                status_o,
  output      logic signed [15:0]  accel_x_o,
  output      logic signed [15:0]  accel_y_o,
  output      logic signed [15:0]  accel_z_o,
  output      logic signed [15:0]  rate_z_o,
  output      logic signed [13:0]  yaw_angle_o,
  output      logic signed [13:0]  pitch_angle_o,
  output      logic signed [13:0]  roll_angle_o
);

  localparam int unsigned QW = ifd_pkg::QUOT_W;

  logic [15:0]   ang_w [3];
  logic [15:0]   ang_mag [3];
  logic [31:0]   ang_prod [3];

  logic          s1_valid_q;
  logic          s1_ok_q;
  logic [15:0]   s1_ax_q, s1_ay_q, s1_az_q, s1_rz_q;
  logic [2:0]    s1_neg_q;
  logic [QW-1:0] s1_quot_q [3];

  logic          out_valid_q;
  logic          out_status_q;
  logic [15:0]   out_ax_q, out_ay_q, out_az_q, out_rz_q;
  logic [13:0]   out_ang_q [3];
  logic [13:0]   ang_res [3];
  logic          adv_out;
  logic          adv_s1;

  // Pipeline flow
  assign adv_out = !out_valid_q || !out_stall_i;
  assign adv_s1  = s1_valid_q && adv_out;
  assign pop_o   = q_valid_i && (!s1_valid_q || adv_out);

  // Magnitude times reciprocal of ten
  assign ang_w[0] = q_head_i.yaw;
  assign ang_w[1] = q_head_i.pitch;
  assign ang_w[2] = q_head_i.roll;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ang_mag[k]  = ang_w[k][15] ? (16'd0 - ang_w[k]) : ang_w[k];
      ang_prod[k] = ang_mag[k] * ifd_pkg::RECIP_TEN;
    end
  end

  // Stage one: quotient magnitudes and raw words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pop_o) begin
      s1_valid_q <= 1'b1;
    end else if (adv_s1) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_ok_q  <= q_head_i.ok;
      s1_ax_q  <= q_head_i.accel_x;
      s1_ay_q  <= q_head_i.accel_y;
      s1_az_q  <= q_head_i.accel_z;
      s1_rz_q  <= q_head_i.rate_z;
      for (int k = 0; k < 3; k++) begin
        s1_neg_q[k]  <= ang_w[k][15];
        s1_quot_q[k] <= ang_prod[k][ifd_pkg::RECIP_SHIFT +: QW];
      end
    end
  end

  // Apply sign and offset
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ang_res[k] = s1_neg_q[k] ? (ifd_pkg::ANGLE_OFS - {1'b0, s1_quot_q[k]})
                               : (ifd_pkg::ANGLE_OFS + {1'b0, s1_quot_q[k]});
    end
  end

  // Result register; zero the data on a checksum mismatch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      out_status_q <= s1_ok_q ? ifd_pkg::STATUS_OK : ifd_pkg::STATUS_ERR;
      out_ax_q     <= s1_ok_q ? s1_ax_q : 16'd0;
      out_ay_q     <= s1_ok_q ? s1_ay_q : 16'd0;
      out_az_q     <= s1_ok_q ? s1_az_q : 16'd0;
      out_rz_q     <= s1_ok_q ? s1_rz_q : 16'd0;
      for (int k = 0; k < 3; k++) begin
        out_ang_q[k] <= s1_ok_q ? ang_res[k] : 14'd0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign accel_x_o     = out_ax_q;
  assign accel_y_o     = out_ay_q;
  assign accel_z_o     = out_az_q;
  assign rate_z_o      = out_rz_q;
  assign yaw_angle_o   = out_ang_q[0];
  assign pitch_angle_o = out_ang_q[1];
  assign roll_angle_o  = out_ang_q[2];

endmodule

`default_nettype wire

/* hw/rtl/imu_frame_deframer_core.sv */
// IMU frame deframer top level: ifd_front, ifd_queue and ifd_back, uses ifd_pkg.
// Throughput: one byte per cycle while rx_stall_o is low; one result per 18-byte frame at most.
// Flow: the beat carrying the last payload byte writes the queue; the frame then
// passes the scaling multiply into the stage-one register, then the result register.
// Reset: asynchronous, active low; returns to header hunt, empties queue and pipe.
`default_nettype none

module imu_frame_deframer_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rx_valid_i,
  output      logic              rx_stall_o,
  input  wire logic [7:0]        rx_byte_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic              status_o,
  output      logic signed [15:0] accel_x_o,
  output      logic signed [15:0] accel_y_o,
  output      logic signed [15:0] accel_z_o,
  output      logic signed [15:0] rate_z_o,
  output      logic signed [13:0] yaw_angle_o,
  output      logic signed [13:0] pitch_angle_o,
  output      logic signed [13:0] roll_angle_o
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  ifd_pkg::ifd_frame_t front_frame;
  ifd_pkg::ifd_frame_t q_head;

  ifd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .rx_stall_o (rx_stall_o),
    .push_o     (q_push),
    .frame_o    (front_frame)
  );

  ifd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .frame_i (front_frame),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  ifd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .accel_x_o     (accel_x_o),
    .accel_y_o     (accel_y_o),
    .accel_z_o     (accel_z_o),
    .rate_z_o      (rate_z_o),
    .yaw_angle_o   (yaw_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .roll_angle_o  (roll_angle_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/ifd_checker.sv */
// Port-level checker for imu_frame_deframer_core and its bind statement.
// Depends on ifd_pkg for status codes.
`default_nettype none

module ifd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              status_o,
  input wire logic signed [15:0] accel_x_o,
  input wire logic signed [15:0] accel_y_o,
  input wire logic signed [15:0] accel_z_o,
  input wire logic signed [15:0] rate_z_o,
  input wire logic signed [13:0] yaw_angle_o,
  input wire logic signed [13:0] pitch_angle_o,
  input wire logic signed [13:0] roll_angle_o
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(accel_x_o)
      && $stable(rate_z_o) && $stable(yaw_angle_o) && $stable(roll_angle_o))
    else $error("stalled result changed");

  // Checksum mismatch carries zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ifd_pkg::STATUS_ERR) |->
      accel_x_o == 16'sd0 && accel_y_o == 16'sd0 && accel_z_o == 16'sd0
      && rate_z_o == 16'sd0 && yaw_angle_o == 14'sd0
      && pitch_angle_o == 14'sd0 && roll_angle_o == 14'sd0)
    else $error("error result with nonzero data");

  // Scaled angles stay within the offset range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ifd_pkg::STATUS_OK) |->
      yaw_angle_o >= -14'sd1476 && yaw_angle_o <= 14'sd5076
      && pitch_angle_o >= -14'sd1476 && pitch_angle_o <= 14'sd5076
      && roll_angle_o >= -14'sd1476 && roll_angle_o <= 14'sd5076)
    else $error("angle out of range");

endmodule

bind imu_frame_deframer_core ifd_checker u_ifd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .accel_x_o     (accel_x_o),
  .accel_y_o     (accel_y_o),
  .accel_z_o     (accel_z_o),
  .rate_z_o      (rate_z_o),
  .yaw_angle_o   (yaw_angle_o),
  .pitch_angle_o (pitch_angle_o),
  .roll_angle_o  (roll_angle_o)
);

`default_nettype wire
